// ===== src/multichannel_to_mono_pcm16_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the multichannel to mono downmix
// Shared property wrappers. They compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_TO_MONO_PCM16_DEFINES_SVH
`define MULTICHANNEL_TO_MONO_PCM16_DEFINES_SVH
`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define MCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("downmix assertion failed");
// The consequent holds a fixed number of cycles after the antecedent.
`define MCM_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("downmix timing assertion failed");
`else
`define MCM_ASSERT_IMPL(lbl, ante, cons)
`define MCM_ASSERT_DELAY(lbl, ante, dly, cons)
`endif
`endif

// ===== src/mcm_pkg.sv =====
// ---------------------------------------------------------------------------
// Downmix package
// Shared types, constants and the reciprocal table for the channel divider.
// ---------------------------------------------------------------------------
package mcm_pkg;

  // Largest channel count supported by the lane array.
  localparam int MAX_CHAN  = 8;
  // Lane slots of the adder tree; slots above the lane count read as zero.
  localparam int PAD_LANES = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 4;
  localparam int FMT_W     = 2;
  localparam int SAMPLE_W  = 16;
  // Accept edge to output register edge, plus one for sampling.
  localparam int PIPE_LAT  = 7;
  // Full scale of the output sample.
  localparam logic [14:0] SCALE = 15'd32767;

  // Register index, taken from paddr[2].
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_SAMPLE_FORMAT = 1'b1;

  typedef enum logic [FMT_W-1:0] {
    FMT_PCM16   = 2'd0,
    FMT_FLOAT32 = 2'd1,
    FMT_BAD     = 2'd2
  } fmt_t;

  // Control that travels alongside each beat through the pipeline.
  typedef struct packed {
    logic             vld;
    logic             pkt_end;
    logic             err;
    logic             pcm;
    logic             nan;
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } mcm_ctl_t;

  // ceil(2^30 / n): exact quotient for dividends below 2^27 after >> 30.
  function automatic logic [30:0] recip_f(input logic [CNT_W-1:0] n);
    logic [30:0] r;
    case (n)
      4'd1:    r = 31'd1073741824;
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd357913942;
      4'd4:    r = 31'd268435456;
      4'd5:    r = 31'd214748365;
      4'd6:    r = 31'd178956971;
      4'd7:    r = 31'd153391690;
      4'd8:    r = 31'd134217728;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mcm_lane.sv =====
// ---------------------------------------------------------------------------
// Downmix lane
// Turns one channel word into a signed 32-bit term: a sign-extended PCM16
// sample, or a float32 converted to saturated Q8.24. Flags NaN inputs.
// ---------------------------------------------------------------------------
module mcm_lane
  import mcm_pkg::*;
(
  input  logic              clk,
  input  logic [WORD_W-1:0] word_i,
  input  logic              use_i,
  input  logic              pcm_i,
  output logic [WORD_W-1:0] val_r,
  output logic              nan_r
);

  logic              sgn;
  logic [7:0]        expo;
  logic [22:0]       mant;
  logic [23:0]       full;
  logic [2:0]        lsh;
  logic [4:0]        rsh;
  logic [WORD_W-1:0] mag;
  logic              is_nan;
  logic [WORD_W-1:0] fval;
  logic [WORD_W-1:0] val_nxt;
  logic              nan_nxt;

  assign sgn  = word_i[31];
  assign expo = word_i[30:23];
  assign mant = word_i[22:0];
  assign full = {1'b1, mant};
  assign lsh  = 3'(expo - 8'd126);
  assign rsh  = 5'(8'd126 - expo);

  // Float magnitude in Q8.24, truncated toward zero.
  always_comb begin
    is_nan = 1'b0;
    if (expo == 8'hFF) begin
      is_nan = (mant != 23'd0);
      mag    = is_nan ? '0 : 32'h8000_0000;
    end else if (expo == 8'd0) begin
      mag = '0;
    end else if (expo >= 8'd134) begin
      mag = 32'h8000_0000;
    end else if (expo >= 8'd126) begin
      mag = WORD_W'(full) << lsh;
    end else if (expo >= 8'd95) begin
      mag = WORD_W'(full) >> rsh;
    end else begin
      mag = '0;
    end
  end

  // Apply the sign and saturate to the Q8.24 range.
  always_comb begin
    if (sgn) begin
      fval = mag[31] ? 32'h8000_0000 : (~mag + 32'd1);
    end else begin
      fval = mag[31] ? 32'h7FFF_FFFF : mag;
    end
  end

  // Unused lanes contribute zero and never flag NaN.
  always_comb begin
    if (!use_i) begin
      val_nxt = '0;
    end else if (pcm_i) begin
      val_nxt = {{16{word_i[15]}}, word_i[15:0]};
    end else begin
      val_nxt = fval;
    end
    nan_nxt = use_i && !pcm_i && is_nan;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    nan_r <= nan_nxt;
  end

endmodule

// ===== src/mcm_merge.sv =====
// ---------------------------------------------------------------------------
// Downmix merge
// Sums the lane terms in a registered tree, divides by the channel count
// with a reciprocal multiply, clamps and scales float results, and forms the
// output beat.
// ---------------------------------------------------------------------------
`include "multichannel_to_mono_pcm16_defines.svh"

module mcm_merge
  import mcm_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcm_ctl_t                            ctl_i,
  input  logic [PAD_LANES-1:0][WORD_W-1:0]    val_i,
  input  logic [PAD_LANES-1:0]                nan_i,
  output logic                                out_valid,
  output logic signed [SAMPLE_W-1:0]          out_mono_sample,
  output logic                                out_packet_end_out,
  output logic                                out_format_error
);

  localparam int PAIRS = PAD_LANES / 2;

  // Pipeline control registers.
  mcm_ctl_t s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r, s6_ctl_r, s7_ctl_r;
  mcm_ctl_t s2_ctl_nxt, s4_ctl_nxt;

  // Payload registers.
  logic signed [WORD_W:0]   s2_pair_r [PAIRS];
  logic signed [WORD_W+2:0] s3_sum_r;
  logic [WORD_W+2:0]        s4_mag_r;
  logic [WORD_W+2:0]        s4_mag_nxt;
  logic [57:0]              s5_prod_r;
  logic                     s5_sat_r;
  logic [26:0]              s6_q;
  logic [24:0]              s6_qm;
  logic [39:0]              s6_scaled_r;
  logic [SAMPLE_W-1:0]      s6_pcm_mag_r;
  logic [SAMPLE_W-1:0]      s7_mag;
  logic [SAMPLE_W-1:0]      s7_sample_nxt;
  logic [SAMPLE_W-1:0]      s7_sample_r;

  // First tree level: pairwise sums and the NaN reduction.
  always_comb begin
    s2_ctl_nxt     = ctl_i;
    s2_ctl_nxt.nan = |nan_i;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PAIRS; i++) begin
      s2_pair_r[i] <= $signed({val_i[2*i][WORD_W-1], val_i[2*i]}) +
                      $signed({val_i[2*i+1][WORD_W-1], val_i[2*i+1]});
    end
  end

  // Second tree level: the full signed sum.
  always_ff @(posedge clk) begin
    s3_sum_r <= (WORD_W+3)'(s2_pair_r[0]) + (WORD_W+3)'(s2_pair_r[1]) +
                (WORD_W+3)'(s2_pair_r[2]) + (WORD_W+3)'(s2_pair_r[3]);
  end

  // Split into sign and magnitude so that division truncates toward zero.
  always_comb begin
    s4_ctl_nxt     = s3_ctl_r;
    s4_ctl_nxt.neg = s3_sum_r[WORD_W+2];
    s4_mag_nxt     = s3_sum_r[WORD_W+2] ? (~s3_sum_r + (WORD_W+3)'(1)) : s3_sum_r;
  end

  always_ff @(posedge clk) begin
    s4_mag_r <= s4_mag_nxt;
  end

  // Reciprocal multiply; a magnitude of at least n * 2^24 clamps to one.
  always_ff @(posedge clk) begin
    s5_prod_r <= 58'(s4_mag_r[26:0]) * 58'(recip_f(s4_ctl_r.cnt));
    s5_sat_r  <= s4_mag_r >= (WORD_W+3)'({s4_ctl_r.cnt, 24'd0});
  end

  // Quotient, clamp and scale by full scale.
  assign s6_q  = s5_prod_r[56:30];
  assign s6_qm = s5_sat_r ? 25'h100_0000 : s6_q[24:0];

  always_ff @(posedge clk) begin
    s6_scaled_r  <= 40'(s6_qm) * 40'(SCALE);
    s6_pcm_mag_r <= s6_q[SAMPLE_W-1:0];
  end

  // Output selection: error gives zero, NaN gives full scale.
  always_comb begin
    s7_mag = s6_ctl_r.pcm ? s6_pcm_mag_r : s6_scaled_r[39:24];
    if (s6_ctl_r.err) begin
      s7_sample_nxt = '0;
    end else if (!s6_ctl_r.pcm && s6_ctl_r.nan) begin
      s7_sample_nxt = 16'h7FFF;
    end else if (s6_ctl_r.neg) begin
      s7_sample_nxt = ~s7_mag + 16'd1;
    end else begin
      s7_sample_nxt = s7_mag;
    end
  end

  always_ff @(posedge clk) begin
    s7_sample_r <= s7_sample_nxt;
  end

  // Control pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
      s6_ctl_r <= '0;
      s7_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s2_ctl_nxt;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s4_ctl_nxt;
      s5_ctl_r <= s4_ctl_r;
      s6_ctl_r <= s5_ctl_r;
      s7_ctl_r <= s6_ctl_r;
    end
  end

  assign out_valid          = s7_ctl_r.vld;
  assign out_mono_sample    = $signed(s7_sample_r);
  assign out_packet_end_out = s7_ctl_r.pkt_end;
  assign out_format_error   = s7_ctl_r.err;

  // A PCM16 sum never reaches the clamp threshold.
  `MCM_ASSERT_IMPL(a_pcm_no_sat, s5_ctl_r.vld && s5_ctl_r.pcm && !s5_ctl_r.err, !s5_sat_r)
  // Lanes flag NaN only in float mode.
  `MCM_ASSERT_IMPL(a_nan_float_only, s2_ctl_r.vld && s2_ctl_r.pcm, !s2_ctl_r.nan)
  // An error beat carries a zero sample.
  `MCM_ASSERT_IMPL(a_err_zero, out_valid && out_format_error, out_mono_sample == '0)

endmodule

// ===== src/multichannel_to_mono_pcm16.sv =====
// ---------------------------------------------------------------------------
// Multichannel to mono PCM16 downmix
// Averages up to eight channel words of one frame, PCM16 or float32, into
// one signed 16-bit mono sample, with one lane per channel.
//
//   Channel   Handshake              Payload
//   input     start / busy           in_chan_word_0..7, in_packet_end_in
//   result    out_valid strobe       out_mono_sample, out_packet_end_out,
//                                    out_format_error
//   config    APB write/read         channel_count at 0x0, sample_format at 0x4
//
// A frame is taken every cycle; busy stays low. Each result passes through
// the lane stage, two adder tree levels, the magnitude stage, the divider
// multiply, the scale multiply and the output register. Results are shown
// for one cycle and cannot be stalled. Reset empties the pipeline and sets
// channel_count to 2 and sample_format to float32.
// ---------------------------------------------------------------------------
`include "multichannel_to_mono_pcm16_defines.svh"

module multichannel_to_mono_pcm16
  import mcm_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHAN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       start,
  output logic                       busy,
  input  logic [WORD_W-1:0]          in_chan_word_0,
  input  logic [WORD_W-1:0]          in_chan_word_1,
  input  logic [WORD_W-1:0]          in_chan_word_2,
  input  logic [WORD_W-1:0]          in_chan_word_3,
  input  logic [WORD_W-1:0]          in_chan_word_4,
  input  logic [WORD_W-1:0]          in_chan_word_5,
  input  logic [WORD_W-1:0]          in_chan_word_6,
  input  logic [WORD_W-1:0]          in_chan_word_7,
  input  logic                       in_packet_end_in,
  // Result channel
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_mono_sample,
  output logic                       out_packet_end_out,
  output logic                       out_format_error,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [CNT_W-1:0]                 cnt_r;
  fmt_t                             fmt_r;
  logic                             cfg_wr;
  logic [CNT_W-1:0]                 eff_cnt;
  logic                             fmt_err;
  mcm_ctl_t                         s1_ctl_r;
  mcm_ctl_t                         s1_ctl_nxt;
  logic [PAD_LANES-1:0][WORD_W-1:0] words;
  logic [PAD_LANES-1:0][WORD_W-1:0] lane_val;
  logic [PAD_LANES-1:0]             lane_nan;

  // The pipeline never stalls, so every start is a beat.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(2);
      fmt_r <= FMT_FLOAT32;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CHANNEL_COUNT: cnt_r <= pwdata[CNT_W-1:0];
        REG_SAMPLE_FORMAT: fmt_r <= fmt_t'(pwdata[FMT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHANNEL_COUNT: prdata = 32'(cnt_r);
      REG_SAMPLE_FORMAT: prdata = 32'(fmt_r);
      default:           prdata = '0;
    endcase
  end

  // Effective count and error decode.
  assign eff_cnt = (cnt_r > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : cnt_r;

  always_comb begin
    case (fmt_r)
      FMT_PCM16:   fmt_err = 1'b0;
      FMT_FLOAT32: fmt_err = 1'b0;
      default:     fmt_err = 1'b1;
    endcase
  end

  always_comb begin
    s1_ctl_nxt         = '0;
    s1_ctl_nxt.vld     = start && !busy;
    s1_ctl_nxt.pkt_end = in_packet_end_in;
    s1_ctl_nxt.err     = fmt_err || (eff_cnt == '0);
    s1_ctl_nxt.pcm     = (fmt_r == FMT_PCM16);
    s1_ctl_nxt.cnt     = eff_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // Gather the channel words.
  assign words[0] = in_chan_word_0;
  assign words[1] = in_chan_word_1;
  assign words[2] = in_chan_word_2;
  assign words[3] = in_chan_word_3;
  assign words[4] = in_chan_word_4;
  assign words[5] = in_chan_word_5;
  assign words[6] = in_chan_word_6;
  assign words[7] = in_chan_word_7;

  // One conversion lane per supported channel; spare tree slots read zero.
  for (genvar g = 0; g < PAD_LANES; g++) begin : g_lane
    if (g < MAX_CHANNELS) begin : g_used
      mcm_lane u_lane (
        .clk    (clk),
        .word_i (words[g]),
        .use_i  (CNT_W'(g) < eff_cnt),
        .pcm_i  (s1_ctl_nxt.pcm),
        .val_r  (lane_val[g]),
        .nan_r  (lane_nan[g])
      );
    end else begin : g_spare
      assign lane_val[g] = '0;
      assign lane_nan[g] = 1'b0;
    end
  end

  mcm_merge u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl_i              (s1_ctl_r),
    .val_i              (lane_val),
    .nan_i              (lane_nan),
    .out_valid          (out_valid),
    .out_mono_sample    (out_mono_sample),
    .out_packet_end_out (out_packet_end_out),
    .out_format_error   (out_format_error)
  );

  // Every accepted beat comes out after the fixed pipeline latency.
  `MCM_ASSERT_DELAY(a_latency, start && !busy, PIPE_LAT, out_valid)

endmodule
